/* rtl/sprite_animation_sequencer_top_defines.svh */
// Assertion macros shared by the sprite animation sequencer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SPRITE_ANIMATION_SEQUENCER_TOP_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define SAS_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, sampled on the rising edge of clk.
`define SAS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

/* rtl/sas_pkg.sv */
// Types and constants of the sprite animation sequencer.
// No dependencies; used by the top level and its checker.
package sas_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_CHECK,
    ST_SEARCH_READ,
    ST_SEARCH_CMP,
    ST_ADDR_REDUCE,
    ST_FRAME_READ,
    ST_FRAME_USE,
    ST_DELAY_DEC,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    ACT_LOAD_FRAME = 2'd0,
    ACT_LOAD_ANIM  = 2'd1,
    ACT_SELECT     = 2'd2,
    ACT_TICK       = 2'd3
  } action_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int SPRITE_W   = 16;
  localparam int DELAY_W    = 16;
  localparam int ID_W       = 16;
  localparam int POS_W      = 8;
  localparam int SLOT_OUT_W = 5;

endpackage

/* rtl/sprite_animation_sequencer_top.sv */
// Sprite animation sequencer: frame store, animation table and playback state.
// Depends on sas_pkg.
//
// The block holds a frame store of (sprite id, delay) entries and a table of
// (animation id, first frame) entries, both loaded through input items. A select
// item walks the animation table from slot 0 until it finds the wanted id, a
// zero id or the end of the table, and on a match restarts playback at that
// animation's first frame. A tick item counts the delay down and, when it
// runs out, steps to the next frame of the list, wrapping to the first frame
// at a zero sprite id. Each input item gives exactly one result transfer,
// which shows the playback state after the item and a not-found flag for a
// select that misses. One input item is worked on at a time: the input side
// stalls from the cycle after a transfer until the result has been written
// to the output register, and the output register lets the next item be
// taken while that result still waits. The id compare, the countdown and
// delay decrements and the frame address reduction go through one shared
// subtractor. A load goes straight to the result. A tick checks the countdown
// and, on an advance, reduces the frame address, reads and uses the frame and
// decrements its delay, repeating reduce, read and use once on a wrap. A select
// reads and compares one table slot at a time and on a hit reduces the address
// and reads the first frame. The frame address (first frame plus position, up
// to 510) is reduced modulo FRAME_DEPTH by repeated subtraction. The frame
// store has no reset: reading an entry that was never written gives undefined
// sprite and delay values. The animation table reads as zero after reset.
module sprite_animation_sequencer_top #(
  parameter int FRAME_DEPTH = 256,
  parameter int ANIM_SLOTS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sas_pkg::ACTION_W-1:0]    action,
  input  logic [sas_pkg::INDEX_W-1:0]     entry_index,
  input  logic [sas_pkg::SPRITE_W-1:0]    frame_sprite,
  input  logic [sas_pkg::DELAY_W-1:0]     frame_delay,
  input  logic [sas_pkg::ID_W-1:0]        wanted_anim_id,
  input  logic [sas_pkg::INDEX_W-1:0]     first_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            status,
  output logic [sas_pkg::SPRITE_W-1:0]    shown_sprite,
  output logic [sas_pkg::SLOT_OUT_W-1:0]  anim_slot,
  output logic [sas_pkg::POS_W-1:0]       frame_position,
  output logic [sas_pkg::DELAY_W-1:0]     ticks_left
);
  import sas_pkg::*;

  // Frame store and animation table geometry.
  localparam int FA_W    = $clog2(FRAME_DEPTH);
  localparam int SLOT_W  = $clog2(ANIM_SLOTS);
  localparam int FRAME_W = SPRITE_W + DELAY_W;
  localparam int ANIM_W  = ID_W + INDEX_W;
  // The unreduced address is a sum of two 8-bit values; the reduction register
  // must also hold FRAME_DEPTH itself for the compare.
  localparam int RED_W   = (FA_W + 1 > INDEX_W + 1) ? FA_W + 1 : INDEX_W + 1;
  // Width of the shared subtractor: wide enough for ids, delays and addresses.
  localparam int UW      = (RED_W > ID_W) ? RED_W : ID_W;

  state_t state, state_next;

  // Storage. Frame entries are {sprite, delay}; table entries are {id, first}.
  logic [FRAME_W-1:0]    frame_mem [FRAME_DEPTH];
  logic [ANIM_W-1:0]     anim_mem  [ANIM_SLOTS];
  logic [ANIM_SLOTS-1:0] anim_valid;

  logic [FRAME_W-1:0]    frame_rd;
  logic [ANIM_W-1:0]     anim_rd;
  logic                  anim_rd_ok;

  // Playback state.
  logic [SLOT_W-1:0]     current_slot;
  logic [INDEX_W-1:0]    list_base;
  logic [POS_W-1:0]      position;
  logic [SPRITE_W-1:0]   current_sprite;
  logic [DELAY_W-1:0]    countdown;

  // Per-item working registers.
  logic [SLOT_W:0]       slot_cnt;
  logic [RED_W-1:0]      addr;
  logic [ID_W-1:0]       want_id;
  logic                  is_tick;
  logic                  wrapped;
  logic                  miss;

  // Shared subtractor.
  logic [UW-1:0]         unit_a;
  logic [UW-1:0]         unit_b;
  logic [UW:0]           unit_diff;
  logic                  unit_borrow;
  logic                  unit_zero;

  logic                  in_xfer;
  logic                  out_free;
  logic                  anim_rd_en;
  logic [FA_W+INDEX_W-1:0]   frame_widx;
  logic [SLOT_W+INDEX_W-1:0] anim_widx;
  logic                  frame_wr_ok;
  logic                  anim_wr_ok;
  logic [ID_W-1:0]       tbl_id;
  logic [INDEX_W-1:0]    tbl_first;
  logic [SPRITE_W-1:0]   rd_sprite;
  logic [DELAY_W-1:0]    rd_delay;
  logic [POS_W-1:0]      pos_inc;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign in_stall    = rst || (state != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;

  assign frame_widx  = {{FA_W{1'b0}}, entry_index};
  assign anim_widx   = {{SLOT_W{1'b0}}, entry_index};
  assign frame_wr_ok = frame_widx < (FA_W + INDEX_W)'(FRAME_DEPTH);
  assign anim_wr_ok  = anim_widx < (SLOT_W + INDEX_W)'(ANIM_SLOTS);
  assign anim_rd_en  = (state == ST_SEARCH_READ) && (slot_cnt != (SLOT_W + 1)'(ANIM_SLOTS));

  // An animation slot that was never written reads as id zero, first frame zero.
  assign tbl_id      = anim_rd_ok ? anim_rd[ANIM_W-1:INDEX_W] : '0;
  assign tbl_first   = anim_rd_ok ? anim_rd[INDEX_W-1:0] : '0;
  assign rd_sprite   = frame_rd[FRAME_W-1:DELAY_W];
  assign rd_delay    = frame_rd[DELAY_W-1:0];
  assign pos_inc     = position + POS_W'(1);
  assign slot_ext    = {{SLOT_OUT_W{1'b0}}, current_slot};

  // The shared unit subtracts in four working states: it tests the countdown
  // for one, compares a table id with the wanted id, reduces the frame address
  // modulo FRAME_DEPTH and decrements a loaded delay with saturation.
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state)
      ST_TICK_CHECK: begin
        unit_a = UW'(countdown);
        unit_b = UW'(1);
      end
      ST_SEARCH_CMP: begin
        unit_a = UW'(tbl_id);
        unit_b = UW'(want_id);
      end
      ST_ADDR_REDUCE: begin
        unit_a = UW'(addr);
        unit_b = UW'(FRAME_DEPTH);
      end
      ST_DELAY_DEC: begin
        unit_a = UW'(rd_delay);
        unit_b = UW'(1);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_borrow = unit_diff[UW];
  assign unit_zero   = (unit_diff[UW-1:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action_t'(action))
            ACT_LOAD_FRAME: state_next = ST_RESULT;
            ACT_LOAD_ANIM:  state_next = ST_RESULT;
            ACT_SELECT:     state_next = ST_SEARCH_READ;
            ACT_TICK:       state_next = ST_TICK_CHECK;
            default:        state_next = ST_RESULT;
          endcase
        end
      end
      ST_TICK_CHECK: begin
        state_next = unit_zero ? ST_ADDR_REDUCE : ST_RESULT;
      end
      ST_SEARCH_READ: begin
        state_next = anim_rd_en ? ST_SEARCH_CMP : ST_RESULT;
      end
      ST_SEARCH_CMP: begin
        if (tbl_id == '0) begin
          state_next = ST_RESULT;
        end else if (unit_zero) begin
          state_next = ST_ADDR_REDUCE;
        end else begin
          state_next = ST_SEARCH_READ;
        end
      end
      ST_ADDR_REDUCE: begin
        state_next = unit_borrow ? ST_FRAME_READ : ST_ADDR_REDUCE;
      end
      ST_FRAME_READ: begin
        state_next = ST_FRAME_USE;
      end
      ST_FRAME_USE: begin
        if (is_tick && !wrapped && (rd_sprite == '0)) begin
          state_next = ST_ADDR_REDUCE;
        end else if (is_tick) begin
          state_next = ST_DELAY_DEC;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_DELAY_DEC: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (in_xfer && (action_t'(action) == ACT_LOAD_FRAME) && frame_wr_ok) begin
      frame_mem[frame_widx[FA_W-1:0]] <= {frame_sprite, frame_delay};
    end
    if (in_xfer && (action_t'(action) == ACT_LOAD_ANIM) && anim_wr_ok) begin
      anim_mem[anim_widx[SLOT_W-1:0]] <= {wanted_anim_id, first_frame};
    end
    if (state == ST_FRAME_READ) begin
      frame_rd <= frame_mem[addr[FA_W-1:0]];
    end
    if (anim_rd_en) begin
      anim_rd    <= anim_mem[slot_cnt[SLOT_W-1:0]];
      anim_rd_ok <= anim_valid[slot_cnt[SLOT_W-1:0]];
    end
  end

  // Sequenced datapath and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_valid     <= '0;
      current_slot   <= '0;
      list_base      <= '0;
      position       <= '0;
      current_sprite <= '0;
      countdown      <= '0;
      slot_cnt       <= '0;
      is_tick        <= 1'b0;
      wrapped        <= 1'b0;
      miss           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // A new result fills the output register; otherwise a taken result
      // empties it.
      if ((state == ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            miss     <= 1'b0;
            wrapped  <= 1'b0;
            is_tick  <= (action_t'(action) == ACT_TICK);
            want_id  <= wanted_anim_id;
            slot_cnt <= '0;
            if ((action_t'(action) == ACT_LOAD_ANIM) && anim_wr_ok) begin
              anim_valid[anim_widx[SLOT_W-1:0]] <= 1'b1;
            end
          end
        end
        ST_TICK_CHECK: begin
          if (unit_zero) begin
            // Countdown ran out: step to the next frame of the list.
            position <= pos_inc;
            addr     <= RED_W'(list_base) + RED_W'(pos_inc);
          end else if (!unit_borrow) begin
            countdown <= unit_diff[DELAY_W-1:0];
          end
        end
        ST_SEARCH_READ: begin
          if (!anim_rd_en) begin
            miss <= 1'b1;
          end
        end
        ST_SEARCH_CMP: begin
          if (tbl_id == '0) begin
            miss <= 1'b1;
          end else if (unit_zero) begin
            current_slot <= slot_cnt[SLOT_W-1:0];
            list_base    <= tbl_first;
            position     <= '0;
            addr         <= RED_W'(tbl_first);
          end else begin
            slot_cnt <= slot_cnt + (SLOT_W + 1)'(1);
          end
        end
        ST_ADDR_REDUCE: begin
          if (!unit_borrow) begin
            addr <= unit_diff[RED_W-1:0];
          end
        end
        ST_FRAME_USE: begin
          if (is_tick && !wrapped && (rd_sprite == '0)) begin
            // End of list: go back to the first frame.
            wrapped  <= 1'b1;
            position <= '0;
            addr     <= RED_W'(list_base);
          end else begin
            current_sprite <= rd_sprite;
            if (!is_tick) begin
              countdown <= rd_delay;
            end
          end
        end
        ST_DELAY_DEC: begin
          countdown <= unit_borrow ? '0 : unit_diff[DELAY_W-1:0];
        end
        ST_RESULT: begin
          if (out_free) begin
            status         <= miss ? STATUS_NOT_FOUND : STATUS_OK;
            shown_sprite   <= current_sprite;
            anim_slot      <= slot_ext[SLOT_OUT_W-1:0];
            frame_position <= position;
            ticks_left     <= countdown;
          end
        end
        default: begin
          miss <= miss;
        end
      endcase
    end
  end

endmodule

/* rtl/sas_checker.sv */
// Port-level checks for the sprite animation sequencer, bound to its top level.
// Depends on sas_pkg and sprite_animation_sequencer_top_defines.svh.
`include "sprite_animation_sequencer_top_defines.svh"

module sas_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [sas_pkg::ACTION_W-1:0]    action,
  input logic [sas_pkg::INDEX_W-1:0]     entry_index,
  input logic [sas_pkg::SPRITE_W-1:0]    frame_sprite,
  input logic [sas_pkg::DELAY_W-1:0]     frame_delay,
  input logic [sas_pkg::ID_W-1:0]        wanted_anim_id,
  input logic [sas_pkg::INDEX_W-1:0]     first_frame,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            status,
  input logic [sas_pkg::SPRITE_W-1:0]    shown_sprite,
  input logic [sas_pkg::SLOT_OUT_W-1:0]  anim_slot,
  input logic [sas_pkg::POS_W-1:0]       frame_position,
  input logic [sas_pkg::DELAY_W-1:0]     ticks_left
);
  import sas_pkg::*;

  // Reset empties the output register.
  `SAS_ASSERT_NEXT(a_reset_empties_output, clk, 1'b0, rst, !out_valid)

  // The block works on one item at a time, so it is busy after every transfer.
  `SAS_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && !in_stall, in_stall)

  // The input side is never open during reset.
  `SAS_ASSERT_NOW(a_stall_in_reset, clk, 1'b0, rst, in_stall)

  // A stalled result stays valid and unchanged.
  `SAS_ASSERT_NEXT(a_stalled_result_holds, clk, rst, out_valid && out_stall,
    out_valid && $stable(status) && $stable(shown_sprite) && $stable(anim_slot)
    && $stable(frame_position) && $stable(ticks_left))

endmodule

bind sprite_animation_sequencer_top sas_checker u_sas_checker (.*);

/* sim/tb_sprite_animation_sequencer_top.sv */
// Self-checking testbench for sprite_animation_sequencer_top.
// Depends on sas_pkg and the sequencer RTL; it keeps its own playback model
// and checks every result transfer against it.
module tb_sprite_animation_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sas_pkg::*;

  localparam int FRAME_DEPTH = 256;
  localparam int ANIM_SLOTS  = 32;

  // This is the quiet time allowed after the last result before the run is
  // closed; a select can walk all 32 table slots.
  localparam int SETTLE_CYCLES  = 100;
  // Cycles without any transfer on either side before the run is abandoned.
  // It lies above the longest receiver hold-off below and a full select walk.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 135;
  localparam int MAX_REPORTS    = 40;

  // One input item as the sender sees it.
  typedef struct packed {
    action_t     act;
    logic [7:0]  idx;
    logic [15:0] spr;
    logic [15:0] dly;
    logic [15:0] id;
    logic [7:0]  first;
  } seq_cmd_t;

  // Playback state reported with each result transfer.
  typedef struct packed {
    logic        status;
    logic [15:0] sprite;
    logic [4:0]  slot;
    logic [7:0]  pos;
    logic [15:0] ticks;
  } playback_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action = '0;
  logic [INDEX_W-1:0]    entry_index = '0;
  logic [SPRITE_W-1:0]   frame_sprite = '0;
  logic [DELAY_W-1:0]    frame_delay = '0;
  logic [ID_W-1:0]       wanted_anim_id = '0;
  logic [INDEX_W-1:0]    first_frame = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic                  status;
  logic [SPRITE_W-1:0]   shown_sprite;
  logic [SLOT_OUT_W-1:0] anim_slot;
  logic [POS_W-1:0]      frame_position;
  logic [DELAY_W-1:0]    ticks_left;

  sprite_animation_sequencer_top #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .ANIM_SLOTS (ANIM_SLOTS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .entry_index   (entry_index),
    .frame_sprite  (frame_sprite),
    .frame_delay   (frame_delay),
    .wanted_anim_id(wanted_anim_id),
    .first_frame   (first_frame),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .shown_sprite  (shown_sprite),
    .anim_slot     (anim_slot),
    .frame_position(frame_position),
    .ticks_left    (ticks_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The testbench's own copy of the block's state. Bit types start at zero,
  // which matches the reset values; fs_written tracks which frame entries hold
  // defined data, since the RTL frame store has no reset.
  bit [15:0] fs_sprite  [FRAME_DEPTH];
  bit [15:0] fs_delay   [FRAME_DEPTH];
  bit        fs_written [FRAME_DEPTH];
  bit [15:0] at_id      [ANIM_SLOTS];
  bit [7:0]  at_first   [ANIM_SLOTS];
  bit [4:0]  pb_slot;
  bit [7:0]  pb_base;
  bit [7:0]  pb_pos;
  bit [15:0] pb_sprite;
  bit [15:0] pb_ticks;

  // Predicted results, oldest first, waiting for their result transfer.
  playback_t playback_q[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int sent_count = 0;
  int results_checked = 0;
  int error_count = 0;
  int miss_count = 0;
  int advance_count = 0;
  int wrap_count = 0;

  // A long receiver hold-off is requested by bumping hold_req_id; the
  // receiver process notices the change and counts the stretch itself.
  int hold_req_id = 0;
  int hold_len = 0;
  int hold_ack_id = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  playback_t rx_want;

  // Walks the animation table the way the block does: the first zero id ends
  // the table, so id zero can never match. Returns -1 on a miss.
  function automatic int find_slot(input bit [15:0] want);
    for (int i = 0; i < ANIM_SLOTS; i++) begin
      if (at_id[i] == 16'd0) return -1;
      if (at_id[i] == want) return i;
    end
    return -1;
  endfunction

  function automatic int table_len();
    int n;
    n = 0;
    while (n < ANIM_SLOTS && at_id[n] != 16'd0) n++;
    return n;
  endfunction

  // Applies one accepted item to the model and returns the expected result.
  function automatic playback_t next_playback(input seq_cmd_t c);
    playback_t r;
    int        hit;
    bit [7:0]  a;
    r.status = STATUS_OK;
    case (c.act)
      ACT_LOAD_FRAME: begin
        fs_sprite[c.idx]  = c.spr;
        fs_delay[c.idx]   = c.dly;
        fs_written[c.idx] = 1'b1;
      end
      ACT_LOAD_ANIM: begin
        // Slots beyond the table depth are silently dropped.
        if (c.idx < ANIM_SLOTS) begin
          at_id[c.idx[4:0]]    = c.id;
          at_first[c.idx[4:0]] = c.first;
        end
      end
      ACT_SELECT: begin
        hit = find_slot(c.id);
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
          miss_count++;
        end else begin
          pb_slot   = 5'(hit);
          pb_base   = at_first[hit];
          pb_pos    = 8'd0;
          pb_sprite = fs_sprite[pb_base];
          pb_ticks  = fs_delay[pb_base];
        end
      end
      default: begin
        if (pb_ticks == 16'd1) begin
          advance_count++;
          pb_pos    = pb_pos + 8'd1;
          a         = pb_base + pb_pos;
          pb_sprite = fs_sprite[a];
          if (pb_sprite == 16'd0) begin
            // End of the list: back to the animation's first frame.
            wrap_count++;
            pb_pos    = 8'd0;
            a         = pb_base;
            pb_sprite = fs_sprite[a];
          end
          pb_ticks = fs_delay[a];
          if (pb_ticks != 16'd0) pb_ticks = pb_ticks - 16'd1;
        end else if (pb_ticks != 16'd0) begin
          pb_ticks = pb_ticks - 16'd1;
        end
      end
    endcase
    r.sprite = pb_sprite;
    r.slot   = pb_slot;
    r.pos    = pb_pos;
    r.ticks  = pb_ticks;
    return r;
  endfunction

  // Tells whether an item would read a frame entry that holds no data yet,
  // and which one. Such reads are outside what the block promises.
  function automatic bit reads_unwritten(input seq_cmd_t c, output bit [7:0] addr);
    int       hit;
    bit [7:0] a;
    addr = 8'd0;
    if (c.act == ACT_SELECT) begin
      hit = find_slot(c.id);
      if (hit >= 0 && !fs_written[at_first[hit]]) begin
        addr = at_first[hit];
        return 1'b1;
      end
    end else if (c.act == ACT_TICK && pb_ticks == 16'd1) begin
      a = pb_base + pb_pos + 8'd1;
      if (!fs_written[a]) begin
        addr = a;
        return 1'b1;
      end
      if (fs_sprite[a] == 16'd0 && !fs_written[pb_base]) begin
        addr = pb_base;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Delays that keep playback moving (2 advances on every tick) dominate;
  // 0, 1 and large values park the counter until the next select.
  function automatic logic [15:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      7, 8:    return 16'd3;
      9:       return 16'($urandom);
      default: return 16'd2;
    endcase
  endfunction

  // Small ids now and then, so that duplicates in the table occur.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic seq_cmd_t cmd(input action_t act, input logic [7:0] idx,
                                   input logic [15:0] spr, input logic [15:0] dly,
                                   input logic [15:0] id, input logic [7:0] first);
    seq_cmd_t c;
    c.act   = act;
    c.idx   = idx;
    c.spr   = spr;
    c.dly   = dly;
    c.id    = id;
    c.first = first;
    return c;
  endfunction

  // Every field gets random bits, including those the action ignores.
  function automatic seq_cmd_t random_fields(input action_t act);
    return cmd(act, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               8'($urandom));
  endfunction

  // One loose random item: mostly ticks and selects of ids in the table,
  // with frame and table writes, misses and id zero mixed in.
  function automatic seq_cmd_t random_command();
    seq_cmd_t c;
    int       r;
    int       n;
    r = $urandom_range(0, 99);
    n = table_len();
    if (r < 50) begin
      c = random_fields(ACT_TICK);
    end else if (r < 70) begin
      c = random_fields(ACT_SELECT);
      r = $urandom_range(0, 99);
      if (r < 70 && n > 0) c.id = at_id[$urandom_range(0, n - 1)];
      else if (r < 88) c.id = pick_id();
      else c.id = 16'd0;
    end else if (r < 90) begin
      c = random_fields(ACT_LOAD_FRAME);
      if ($urandom_range(0, 3) == 0) c.spr = 16'd0;
      c.dly = pick_delay();
    end else begin
      c = random_fields(ACT_LOAD_ANIM);
      if ($urandom_range(0, 9) < 7) c.idx = 8'($urandom_range(0, ANIM_SLOTS - 1));
      c.id = ($urandom_range(0, 9) == 0) ? 16'd0 : pick_id();
    end
    return c;
  endfunction

  // Sends one item and records its predicted result once the transfer has
  // happened. An item that would read an empty frame entry is turned into a
  // write of that entry, so the store fills in where playback needs it.
  task automatic send_item(input seq_cmd_t c);
    bit [7:0] gap_addr;
    if (reads_unwritten(c, gap_addr)) begin
      c = random_fields(ACT_LOAD_FRAME);
      c.idx = gap_addr;
      if ($urandom_range(0, 3) == 0) c.spr = 16'd0;
      c.dly = pick_delay();
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= c.act;
    entry_index    <= c.idx;
    frame_sprite   <= c.spr;
    frame_delay    <= c.dly;
    wanted_anim_id <= c.id;
    first_frame    <= c.first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    playback_q.push_back(next_playback(c));
    sent_count++;
  endtask

  // The sender goes quiet until every predicted result has been seen.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (playback_q.size() != 0);
  endtask

  // A well-formed animation: a short frame list closed by a zero sprite id,
  // a table entry pointing at it, and a select of its id.
  task automatic send_animation();
    seq_cmd_t   c;
    logic [7:0] list_at;
    logic [15:0] id;
    int         len;
    int         n;
    list_at = 8'($urandom);
    len     = $urandom_range(1, 5);
    for (int k = 0; k <= len; k++) begin
      c     = random_fields(ACT_LOAD_FRAME);
      c.idx = list_at + 8'(k);
      c.spr = (k == len) ? 16'd0 : 16'($urandom_range(1, 65535));
      c.dly = pick_delay();
      send_item(c);
    end
    n       = table_len();
    id      = pick_id();
    c       = random_fields(ACT_LOAD_ANIM);
    c.idx   = 8'($urandom_range(0, (n < ANIM_SLOTS) ? n : ANIM_SLOTS - 1));
    c.id    = id;
    c.first = list_at;
    send_item(c);
    c    = random_fields(ACT_SELECT);
    c.id = id;
    send_item(c);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch: %s on result %0d, expected %h, got %h",
               what, results_checked, want, got);
  endtask

  // Receiver: checks each result transfer against the oldest prediction and
  // decides the stall for the next cycle. Values are read right after the
  // edge, so they are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (playback_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 16'd0, shown_sprite);
      end else begin
        rx_want = playback_q.pop_front();
        if (status !== rx_want.status)
          report_mismatch("status", 16'(rx_want.status), 16'(status));
        if (shown_sprite !== rx_want.sprite)
          report_mismatch("shown_sprite", rx_want.sprite, shown_sprite);
        if (anim_slot !== rx_want.slot)
          report_mismatch("anim_slot", 16'(rx_want.slot), 16'(anim_slot));
        if (frame_position !== rx_want.pos)
          report_mismatch("frame_position", 16'(rx_want.pos), 16'(frame_position));
        if (ticks_left !== rx_want.ticks)
          report_mismatch("ticks_left", rx_want.ticks, ticks_left);
      end
      results_checked++;
    end
    if (hold_req_id != hold_ack_id) begin
      hold_ack_id = hold_req_id;
      hold_left   = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, playback_q.size());
      $display("[sprite_animation_sequencer_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hand-built items: the empty table at reset, lists that run across the
  // top of the frame store, field extremes, a write to the frame on show,
  // an ignored table write, misses, id zero, and each counter case.
  task automatic test_directed();
    // Counter at zero right after reset: a tick changes nothing.
    send_item(cmd(ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    // Empty table: id zero and the largest id both miss.
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 8'h00));
    // A list that starts at 254 and wraps through the store's end to entry 1.
    send_item(cmd(ACT_LOAD_FRAME, 8'd254, 16'hFFFF, 16'd2, 16'h0000, 8'h00));
    send_item(cmd(ACT_LOAD_FRAME, 8'd255, 16'h1234, 16'd2, 16'h0000, 8'h00));
    send_item(cmd(ACT_LOAD_FRAME, 8'd0, 16'h8001, 16'd2, 16'h0000, 8'h00));
    send_item(cmd(ACT_LOAD_FRAME, 8'd1, 16'h0000, 16'hFFFF, 16'h0000, 8'h00));
    // A single frame with delay zero, and one with the largest delay.
    send_item(cmd(ACT_LOAD_FRAME, 8'd10, 16'h0ABC, 16'd0, 16'h0000, 8'h00));
    send_item(cmd(ACT_LOAD_FRAME, 8'd20, 16'h00FF, 16'hFFFF, 16'h0000, 8'h00));
    send_item(cmd(ACT_LOAD_ANIM, 8'd0, 16'h0000, 16'h0000, 16'hFFFF, 8'd254));
    send_item(cmd(ACT_LOAD_ANIM, 8'd1, 16'h0000, 16'h0000, 16'h0001, 8'd10));
    send_item(cmd(ACT_LOAD_ANIM, 8'd2, 16'h0000, 16'h0000, 16'h7777, 8'd20));
    // Slot 200 lies beyond the table, so this write must be dropped.
    send_item(cmd(ACT_LOAD_ANIM, 8'd200, 16'h0000, 16'h0000, 16'h0005, 8'd0));
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 8'h00));
    // Count down once, advance twice, then wrap at the zero sprite.
    repeat (4) send_item(cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    // Rewriting the frame on show leaves the shown state alone.
    send_item(cmd(ACT_LOAD_FRAME, 8'd254, 16'h4321, 16'd7, 16'h0000, 8'h00));
    send_item(cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'h0005, 8'h00));
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'h0001, 8'h00));
    send_item(cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    // Id zero misses even though the table now holds entries.
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_item(cmd(ACT_SELECT, 8'h00, 16'h0000, 16'h0000, 16'h7777, 8'h00));
    send_item(cmd(ACT_TICK, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    wait_all_results();
  endtask

  // Random traffic in four idling phases: none, sender idle, receiver
  // stalling, and both. Each phase closes with the sender waiting until
  // every result is in.
  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = (phase == 1) ? 85 : (phase == 3) ? 38 : 0;
      rx_stall_pct = (phase == 2) ? 85 : (phase == 3) ? 38 : 0;
      goal = sent_count + PHASE_ITEMS;
      while (sent_count < goal) begin
        if ($urandom_range(0, 99) < 12) send_animation();
        else send_item(random_command());
      end
      wait_all_results();
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the output
  // register and the block both fill and the input stalls.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_len     = 400;
    hold_req_id++;
    repeat (30) send_item(random_command());
    wait_all_results();
  endtask

  // Fills the whole frame store with nonzero sprites and delay 2 and the
  // whole table with distinct ids, then plays the last slot's animation for
  // more than 256 frames, so the position runs past 255 and wraps to 0.
  // Two selects that walk the full table and miss are mixed in.
  task automatic test_long_playback();
    seq_cmd_t    c;
    logic [15:0] missing;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      c     = random_fields(ACT_LOAD_FRAME);
      c.idx = 8'(i);
      c.spr = 16'($urandom_range(1, 65535));
      c.dly = 16'd2;
      send_item(c);
    end
    for (int i = 0; i < ANIM_SLOTS; i++) begin
      c     = random_fields(ACT_LOAD_ANIM);
      c.idx = 8'(i);
      // Distinct low five bits keep the ids unique, and i + 1 keeps them nonzero.
      c.id  = 16'(i + 1) | (16'($urandom_range(0, 2047)) << 5);
      send_item(c);
    end
    tx_idle_pct  = 38;
    rx_stall_pct = 38;
    c    = random_fields(ACT_SELECT);
    c.id = at_id[ANIM_SLOTS - 1];
    send_item(c);
    for (int t = 0; t < 270; t++) begin
      if (t == 90 || t == 180) begin
        do missing = 16'($urandom_range(1, 65535)); while (find_slot(missing) >= 0);
        c    = random_fields(ACT_SELECT);
        c.id = missing;
      end else begin
        c = random_fields(ACT_TICK);
      end
      send_item(c);
    end
    wait_all_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_long_playback();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d items through loads, selects and ticks; %0d results checked.",
             sent_count, results_checked);
    $display("Saw %0d select misses, %0d frame advances and %0d list wraps.",
             miss_count, advance_count, wrap_count);
    if (error_count == 0 && playback_q.size() == 0) begin
      $display("[sprite_animation_sequencer_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               playback_q.size());
      $display("[sprite_animation_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
